// ===== rtl/rha_pkg.sv =====
// ---------------------------------------------------------------------------
// rha_pkg: shared types and constants of the range heap allocator
// widths, table depths, request codes and controller/datapath interface
// ---------------------------------------------------------------------------
package rha_pkg;

	localparam int HEAP_BITS       = 20;
	localparam int MAX_FREE_RANGES = 32;
	localparam int MAX_ALLOCATIONS = 64;

	localparam int OFF_W  = HEAP_BITS + 1;
	localparam int FIDX_W = $clog2(MAX_FREE_RANGES);
	localparam int FCNT_W = $clog2(MAX_FREE_RANGES + 1);
	localparam int AIDX_W = $clog2(MAX_ALLOCATIONS);
	localparam int LIVE_W = $clog2(MAX_ALLOCATIONS + 1);
	localparam int IDX_W  = (AIDX_W > FCNT_W) ? AIDX_W : FCNT_W;
	localparam int ADDR_W = 32;
	localparam int CFG_W  = 32;

	localparam logic [OFF_W-1:0] HEAP_LIMIT = OFF_W'(1) << HEAP_BITS;

	localparam logic [1:0] MODE_LOW  = 2'd0;
	localparam logic [1:0] MODE_HIGH = 2'd1;
	localparam logic [1:0] MODE_FREE = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_CAP  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD      = 3'd1,
		ST_NOFIT    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} result_code_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] len;
	} span_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_INIT, OP_LOAD, OP_SLOT_NEXT, OP_SLOT_TAKE,
		OP_FREAD, OP_FLOAD, OP_FALIGN, OP_FCMP, OP_ACALC, OP_ACALC2, OP_ACALC3,
		OP_WR_SHRINK, OP_WR_LEAD, OP_REM_PICK, OP_INS_PICK,
		OP_AREAD, OP_ACMP, OP_PREAD, OP_PCHK, OP_PJOIN,
		OP_WR_BOTH, OP_WR_PREV, OP_WR_NEXT, OP_REM_POS, OP_INS_POS,
		OP_SH_RD, OP_SH_WR, OP_REM_DONE, OP_INS_DONE,
		OP_DONE_OK, OP_DONE_ERR
	} dp_op_t;

	typedef struct packed {
		dp_op_t       op;
		result_code_t code;
	} rha_cmd_t;

	typedef struct packed {
		logic bad;
		logic is_free;
		logic slot_free;
		logic idx_last;
		logic f_end;
		logic stop;
		logic found;
		logic same;
		logic zero;
		logic tail_nz;
		logic ftab_full;
		logic hit;
		logic pos_end;
		logic p_less;
		logic jn;
		logic jp;
		logic sh_end;
		logic sh_rem;
	} rha_sts_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_CHECK, S_SLOT,
		S_FISSUE, S_FLOAD, S_FALIGN, S_FCMP, S_FEND,
		S_ACALC2, S_ACALC3, S_ADEC, S_AINS,
		S_RISSUE, S_RCMP, S_PISSUE, S_PCHK, S_PJOIN, S_PACT, S_PREM,
		S_SHCHK, S_SHRD, S_SHWR, S_SHDONE, S_COMMIT
	} rha_state_t;

endpackage

// ===== rtl/rha_ctrl.sv =====
// ---------------------------------------------------------------------------
// rha_ctrl: request sequencer
// walks slot search, free range scan, placement, lookup, merge and shifts
// ---------------------------------------------------------------------------
module rha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rha_pkg::rha_sts_t sts,
	output rha_pkg::rha_cmd_t cmd,
	output logic              busy
);

	rha_pkg::rha_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rha_pkg::S_INIT;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rha_pkg::S_INIT:   state_d = rha_pkg::S_IDLE;
			rha_pkg::S_IDLE:   if (start) state_d = rha_pkg::S_CHECK;
			rha_pkg::S_CHECK: begin
				if (sts.bad) state_d = rha_pkg::S_IDLE;
				else if (sts.is_free) state_d = rha_pkg::S_RISSUE;
				else state_d = rha_pkg::S_SLOT;
			end
			rha_pkg::S_SLOT: begin
				if (sts.slot_free) state_d = rha_pkg::S_FISSUE;
				else if (sts.idx_last) state_d = rha_pkg::S_IDLE;
			end
			rha_pkg::S_FISSUE: state_d = sts.f_end ? rha_pkg::S_FEND : rha_pkg::S_FLOAD;
			rha_pkg::S_FLOAD:  state_d = rha_pkg::S_FALIGN;
			rha_pkg::S_FALIGN: state_d = rha_pkg::S_FCMP;
			rha_pkg::S_FCMP:   state_d = sts.stop ? rha_pkg::S_FEND : rha_pkg::S_FISSUE;
			rha_pkg::S_FEND:   state_d = sts.found ? rha_pkg::S_ACALC2 : rha_pkg::S_IDLE;
			rha_pkg::S_ACALC2: state_d = rha_pkg::S_ACALC3;
			rha_pkg::S_ACALC3: state_d = rha_pkg::S_ADEC;
			rha_pkg::S_ADEC: begin
				if (sts.same) state_d = sts.zero ? rha_pkg::S_SHCHK : rha_pkg::S_COMMIT;
				else if (sts.tail_nz && sts.ftab_full) state_d = rha_pkg::S_IDLE;
				else state_d = sts.tail_nz ? rha_pkg::S_AINS : rha_pkg::S_COMMIT;
			end
			rha_pkg::S_AINS:   state_d = rha_pkg::S_SHCHK;
			rha_pkg::S_RISSUE: state_d = rha_pkg::S_RCMP;
			rha_pkg::S_RCMP: begin
				if (sts.hit) state_d = rha_pkg::S_PISSUE;
				else if (sts.idx_last) state_d = rha_pkg::S_IDLE;
				else state_d = rha_pkg::S_RISSUE;
			end
			rha_pkg::S_PISSUE: state_d = sts.pos_end ? rha_pkg::S_PJOIN : rha_pkg::S_PCHK;
			rha_pkg::S_PCHK:   state_d = sts.p_less ? rha_pkg::S_PISSUE : rha_pkg::S_PJOIN;
			rha_pkg::S_PJOIN:  state_d = rha_pkg::S_PACT;
			rha_pkg::S_PACT: begin
				if (sts.jn && sts.jp) state_d = rha_pkg::S_PREM;
				else if (sts.jn || sts.jp) state_d = rha_pkg::S_COMMIT;
				else if (sts.ftab_full) state_d = rha_pkg::S_IDLE;
				else state_d = rha_pkg::S_SHCHK;
			end
			rha_pkg::S_PREM:   state_d = rha_pkg::S_SHCHK;
			rha_pkg::S_SHCHK:  state_d = sts.sh_end ? rha_pkg::S_SHDONE : rha_pkg::S_SHRD;
			rha_pkg::S_SHRD:   state_d = rha_pkg::S_SHWR;
			rha_pkg::S_SHWR:   state_d = rha_pkg::S_SHCHK;
			rha_pkg::S_SHDONE: state_d = rha_pkg::S_COMMIT;
			rha_pkg::S_COMMIT: state_d = rha_pkg::S_IDLE;
			default:           state_d = rha_pkg::S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.op   = rha_pkg::OP_NONE;
		cmd.code = rha_pkg::ST_OK;
		case (state_q)
			rha_pkg::S_INIT: cmd.op = rha_pkg::OP_INIT;
			rha_pkg::S_IDLE: if (start) cmd.op = rha_pkg::OP_LOAD;
			rha_pkg::S_CHECK: begin
				if (sts.bad) begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_BAD;
				end
			end
			rha_pkg::S_SLOT: begin
				if (sts.slot_free) cmd.op = rha_pkg::OP_SLOT_TAKE;
				else if (sts.idx_last) begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_FULL;
				end else cmd.op = rha_pkg::OP_SLOT_NEXT;
			end
			rha_pkg::S_FISSUE: if (!sts.f_end) cmd.op = rha_pkg::OP_FREAD;
			rha_pkg::S_FLOAD:  cmd.op = rha_pkg::OP_FLOAD;
			rha_pkg::S_FALIGN: cmd.op = rha_pkg::OP_FALIGN;
			rha_pkg::S_FCMP:   cmd.op = rha_pkg::OP_FCMP;
			rha_pkg::S_FEND: begin
				if (sts.found) cmd.op = rha_pkg::OP_ACALC;
				else begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_NOFIT;
				end
			end
			rha_pkg::S_ACALC2: cmd.op = rha_pkg::OP_ACALC2;
			rha_pkg::S_ACALC3: cmd.op = rha_pkg::OP_ACALC3;
			rha_pkg::S_ADEC: begin
				if (sts.same) cmd.op = sts.zero ? rha_pkg::OP_REM_PICK : rha_pkg::OP_WR_SHRINK;
				else if (sts.tail_nz && sts.ftab_full) begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_FULL;
				end else cmd.op = rha_pkg::OP_WR_LEAD;
			end
			rha_pkg::S_AINS:   cmd.op = rha_pkg::OP_INS_PICK;
			rha_pkg::S_RISSUE: cmd.op = rha_pkg::OP_AREAD;
			rha_pkg::S_RCMP: begin
				if (!sts.hit && sts.idx_last) begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_NOTFOUND;
				end else cmd.op = rha_pkg::OP_ACMP;
			end
			rha_pkg::S_PISSUE: if (!sts.pos_end) cmd.op = rha_pkg::OP_PREAD;
			rha_pkg::S_PCHK:   cmd.op = rha_pkg::OP_PCHK;
			rha_pkg::S_PJOIN:  cmd.op = rha_pkg::OP_PJOIN;
			rha_pkg::S_PACT: begin
				if (sts.jn && sts.jp) cmd.op = rha_pkg::OP_WR_BOTH;
				else if (sts.jp) cmd.op = rha_pkg::OP_WR_PREV;
				else if (sts.jn) cmd.op = rha_pkg::OP_WR_NEXT;
				else if (sts.ftab_full) begin
					cmd.op   = rha_pkg::OP_DONE_ERR;
					cmd.code = rha_pkg::ST_FULL;
				end else cmd.op = rha_pkg::OP_INS_POS;
			end
			rha_pkg::S_PREM:   cmd.op = rha_pkg::OP_REM_POS;
			rha_pkg::S_SHRD:   cmd.op = rha_pkg::OP_SH_RD;
			rha_pkg::S_SHWR:   cmd.op = rha_pkg::OP_SH_WR;
			rha_pkg::S_SHDONE: cmd.op = sts.sh_rem ? rha_pkg::OP_REM_DONE : rha_pkg::OP_INS_DONE;
			rha_pkg::S_COMMIT: cmd.op = rha_pkg::OP_DONE_OK;
			default:           cmd.op = rha_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != rha_pkg::S_IDLE);

endmodule

// ===== rtl/rha_dp.sv =====
// ---------------------------------------------------------------------------
// rha_dp: allocator datapath
// free range and allocation memories, scan registers, arithmetic, result
// ---------------------------------------------------------------------------
module rha_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rha_pkg::rha_cmd_t                 cmd,
	output rha_pkg::rha_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [rha_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [1:0]                        mode,
	input  logic [rha_pkg::OFF_W-1:0]         request_size,
	input  logic [rha_pkg::OFF_W-1:0]         alignment,
	input  logic [rha_pkg::ADDR_W-1:0]        free_address,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [rha_pkg::ADDR_W-1:0]        address,
	output logic [rha_pkg::OFF_W-1:0]         bytes_in_use,
	output logic [rha_pkg::LIVE_W-1:0]        live_allocations
);

	localparam int W = rha_pkg::OFF_W;
	localparam int A = rha_pkg::ADDR_W;

	rha_pkg::span_t fmem [rha_pkg::MAX_FREE_RANGES];
	rha_pkg::span_t amem [rha_pkg::MAX_ALLOCATIONS];
	rha_pkg::span_t frd_q, ard_q, cur_q, prev_q, nxt_q, ins_q, fwd;

	logic [A-1:0]                      base_q, faddr_q, address_q;
	logic [W-1:0]                      cap_q, used_q, size_q, align_q, am1_q;
	logic [rha_pkg::LIVE_W-1:0]        live_q;
	logic [rha_pkg::FCNT_W-1:0]        fcnt_q, pos_q, sj_q, si_q;
	logic [rha_pkg::MAX_ALLOCATIONS-1:0] valid_q;
	logic [1:0]                        mode_q;
	logic [rha_pkg::IDX_W-1:0]         idx_q;
	logic [rha_pkg::AIDX_W-1:0]        slot_q;
	logic [rha_pkg::FIDX_W-1:0]        pick_q, fra, fwa;
	logic                              fwe, found_q, fit_q, same_q, zero_q;
	logic                              has_next_q, jn_q, jp_q, sdir_q, done_q;
	logic [A:0]                        start_q, a_q, best_q, amask, a_off;
	logic [W-1:0]                      room_q, pk_end_q, at_q, aend_q, lead_q;
	logic [W-1:0]                      tail_q, foff_q, flen_q, fend_q, sum_pl_q;
	logic [W-1:0]                      am1_c, cap_c;
	logic [2:0]                        status_q;
	logic                              high, ok, accept, cap_wr;

	assign high   = (mode_q == rha_pkg::MODE_HIGH);
	assign amask  = ~{{(A+1-W){1'b0}}, am1_q};
	assign a_off  = a_q - start_q;
	assign ok     = fit_q && (a_q >= start_q) && (a_off <= {{(A+1-W){1'b0}}, room_q});
	assign accept = ok && (!found_q || (high && (a_q > best_q)));
	assign am1_c  = align_q - W'(1);
	assign cap_wr = cfg_we && (cfg_index == rha_pkg::REG_CAP);
	assign cap_c  = (cfg_wdata[W-1:0] > rha_pkg::HEAP_LIMIT) ? rha_pkg::HEAP_LIMIT
		: cfg_wdata[W-1:0];

	// status towards the sequencer
	always_comb begin
		sts.bad = (mode_q == rha_pkg::MODE_LOW || mode_q == rha_pkg::MODE_HIGH)
			? (size_q == '0 || align_q == '0 || (align_q & am1_c) != '0)
			: (mode_q != rha_pkg::MODE_FREE);
		sts.is_free   = (mode_q == rha_pkg::MODE_FREE);
		sts.slot_free = !valid_q[idx_q[rha_pkg::AIDX_W-1:0]];
		sts.idx_last  = (idx_q[rha_pkg::AIDX_W-1:0] == {rha_pkg::AIDX_W{1'b1}});
		sts.f_end     = (idx_q == rha_pkg::IDX_W'(fcnt_q));
		sts.stop      = !high && accept;
		sts.found     = found_q;
		sts.same      = same_q;
		sts.zero      = zero_q;
		sts.tail_nz   = (tail_q != '0);
		sts.ftab_full = (fcnt_q == rha_pkg::FCNT_W'(rha_pkg::MAX_FREE_RANGES));
		sts.hit       = valid_q[idx_q[rha_pkg::AIDX_W-1:0]]
			&& ((base_q + A'(ard_q.off)) == faddr_q);
		sts.pos_end   = (pos_q == fcnt_q);
		sts.p_less    = (frd_q.off < foff_q);
		sts.jn        = jn_q;
		sts.jp        = jp_q;
		sts.sh_end    = sdir_q ? (({1'b0, sj_q} + 1'b1) >= {1'b0, fcnt_q}) : (sj_q == si_q);
		sts.sh_rem    = sdir_q;
	end

	// free table read address and write port
	always_comb begin
		fra = idx_q[rha_pkg::FIDX_W-1:0];
		case (cmd.op)
			rha_pkg::OP_PREAD: fra = pos_q[rha_pkg::FIDX_W-1:0];
			rha_pkg::OP_SH_RD: fra = sdir_q ? rha_pkg::FIDX_W'(sj_q + 1'b1)
				: rha_pkg::FIDX_W'(sj_q - 1'b1);
			default:           fra = idx_q[rha_pkg::FIDX_W-1:0];
		endcase
	end

	always_comb begin
		fwe = 1'b1;
		fwa = pick_q;
		fwd = '{off: cur_q.off, len: lead_q};
		if (cap_wr) begin
			fwa = '0;
			fwd = '{off: '0, len: cap_c};
		end else begin
			case (cmd.op)
				rha_pkg::OP_INIT: begin
					fwa = '0;
					fwd = '{off: '0, len: cap_q};
				end
				rha_pkg::OP_WR_SHRINK: fwd = '{off: cur_q.off + size_q, len: cur_q.len - size_q};
				rha_pkg::OP_WR_LEAD:   fwd = '{off: cur_q.off, len: lead_q};
				rha_pkg::OP_WR_BOTH: begin
					fwa = rha_pkg::FIDX_W'(pos_q - 1'b1);
					fwd = '{off: prev_q.off, len: sum_pl_q + nxt_q.len};
				end
				rha_pkg::OP_WR_PREV: begin
					fwa = rha_pkg::FIDX_W'(pos_q - 1'b1);
					fwd = '{off: prev_q.off, len: sum_pl_q};
				end
				rha_pkg::OP_WR_NEXT: begin
					fwa = pos_q[rha_pkg::FIDX_W-1:0];
					fwd = '{off: foff_q, len: nxt_q.len + flen_q};
				end
				rha_pkg::OP_SH_WR: begin
					fwa = sj_q[rha_pkg::FIDX_W-1:0];
					fwd = frd_q;
				end
				rha_pkg::OP_INS_DONE: begin
					fwa = si_q[rha_pkg::FIDX_W-1:0];
					fwd = ins_q;
				end
				default: fwe = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fwe) fmem[fwa] <= fwd;
		frd_q <= fmem[fra];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == rha_pkg::OP_DONE_OK && !sts.is_free)
			amem[slot_q] <= '{off: at_q, len: size_q};
		ard_q <= amem[idx_q[rha_pkg::AIDX_W-1:0]];
	end

	// control and bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			cap_q   <= rha_pkg::HEAP_LIMIT;
			fcnt_q  <= rha_pkg::FCNT_W'(1);
			valid_q <= '0;
			used_q  <= '0;
			live_q  <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			sdir_q  <= 1'b0;
		end else begin
			done_q <= (cmd.op == rha_pkg::OP_DONE_OK) || (cmd.op == rha_pkg::OP_DONE_ERR);
			if (cfg_we && cfg_index == rha_pkg::REG_BASE) base_q <= cfg_wdata[A-1:0];
			if (cap_wr) begin
				cap_q   <= cap_c;
				fcnt_q  <= rha_pkg::FCNT_W'(cap_c != '0);
				valid_q <= '0;
				used_q  <= '0;
				live_q  <= '0;
			end
			case (cmd.op)
				rha_pkg::OP_LOAD:     found_q <= 1'b0;
				rha_pkg::OP_FCMP:     if (accept) found_q <= 1'b1;
				rha_pkg::OP_REM_PICK,
				rha_pkg::OP_REM_POS:  sdir_q <= 1'b1;
				rha_pkg::OP_INS_PICK,
				rha_pkg::OP_INS_POS:  sdir_q <= 1'b0;
				rha_pkg::OP_REM_DONE: fcnt_q <= fcnt_q - 1'b1;
				rha_pkg::OP_INS_DONE: fcnt_q <= fcnt_q + 1'b1;
				rha_pkg::OP_DONE_OK: begin
					if (sts.is_free) begin
						valid_q[slot_q] <= 1'b0;
						used_q          <= used_q - flen_q;
						live_q          <= live_q - 1'b1;
					end else begin
						valid_q[slot_q] <= 1'b1;
						used_q          <= used_q + size_q;
						live_q          <= live_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		am1_q  <= am1_c;
		fend_q <= foff_q + flen_q;
		case (cmd.op)
			rha_pkg::OP_LOAD: begin
				mode_q     <= mode;
				size_q     <= request_size;
				align_q    <= alignment;
				faddr_q    <= free_address;
				idx_q      <= '0;
				pos_q      <= '0;
				has_next_q <= 1'b0;
			end
			rha_pkg::OP_SLOT_NEXT: idx_q <= idx_q + 1'b1;
			rha_pkg::OP_SLOT_TAKE: begin
				slot_q <= idx_q[rha_pkg::AIDX_W-1:0];
				idx_q  <= '0;
			end
			rha_pkg::OP_FLOAD: begin
				cur_q   <= frd_q;
				start_q <= {1'b0, base_q} + (A+1)'(frd_q.off);
				room_q  <= frd_q.len - size_q;
				fit_q   <= (frd_q.len >= size_q);
			end
			rha_pkg::OP_FALIGN: a_q <= (high ? (start_q + (A+1)'(room_q))
				: (start_q + (A+1)'(am1_q))) & amask;
			rha_pkg::OP_FCMP: begin
				idx_q <= idx_q + 1'b1;
				if (accept) begin
					pick_q   <= idx_q[rha_pkg::FIDX_W-1:0];
					best_q   <= a_q;
					prev_q   <= cur_q;
					pk_end_q <= cur_q.off + cur_q.len;
				end
			end
			rha_pkg::OP_ACALC: begin
				at_q  <= W'(best_q - {1'b0, base_q});
				cur_q <= prev_q;
			end
			rha_pkg::OP_ACALC2: begin
				aend_q <= at_q + size_q;
				lead_q <= at_q - cur_q.off;
				same_q <= (at_q == cur_q.off);
				zero_q <= (cur_q.len == size_q);
			end
			rha_pkg::OP_ACALC3: tail_q <= pk_end_q - aend_q;
			rha_pkg::OP_REM_PICK: sj_q <= rha_pkg::FCNT_W'(pick_q);
			rha_pkg::OP_INS_PICK: begin
				sj_q  <= fcnt_q;
				si_q  <= rha_pkg::FCNT_W'(pick_q) + 1'b1;
				ins_q <= '{off: aend_q, len: tail_q};
			end
			rha_pkg::OP_ACMP: begin
				if (sts.hit) begin
					slot_q <= idx_q[rha_pkg::AIDX_W-1:0];
					foff_q <= ard_q.off;
					flen_q <= ard_q.len;
				end else idx_q <= idx_q + 1'b1;
			end
			rha_pkg::OP_PCHK: begin
				if (sts.p_less) begin
					prev_q <= frd_q;
					pos_q  <= pos_q + 1'b1;
				end else begin
					nxt_q      <= frd_q;
					has_next_q <= 1'b1;
				end
			end
			rha_pkg::OP_PJOIN: begin
				jn_q     <= has_next_q && (fend_q == nxt_q.off);
				jp_q     <= (pos_q != '0) && ((prev_q.off + prev_q.len) == foff_q);
				sum_pl_q <= prev_q.len + flen_q;
			end
			rha_pkg::OP_REM_POS: sj_q <= pos_q;
			rha_pkg::OP_INS_POS: begin
				sj_q  <= fcnt_q;
				si_q  <= pos_q;
				ins_q <= '{off: foff_q, len: flen_q};
			end
			rha_pkg::OP_SH_WR: sj_q <= sdir_q ? sj_q + 1'b1 : sj_q - 1'b1;
			rha_pkg::OP_DONE_OK: begin
				status_q  <= rha_pkg::ST_OK;
				address_q <= sts.is_free ? '0 : best_q[A-1:0];
			end
			rha_pkg::OP_DONE_ERR: begin
				status_q  <= cmd.code;
				address_q <= '0;
			end
			default: ;
		endcase
	end

	assign done             = done_q;
	assign status           = status_q;
	assign address          = address_q;
	assign bytes_in_use     = used_q;
	assign live_allocations = live_q;

endmodule

// ===== rtl/range_heap_allocator.sv =====
// ---------------------------------------------------------------------------
// range_heap_allocator: first fit or high end allocator with coalescing
// one heap at a configurable base, sorted free ranges, live allocation table
// ---------------------------------------------------------------------------
// usage
//   a request word is taken at a clock edge with start high and busy low
//   mode selects allocate lowest fit, allocate at high end, or free
//   exactly one result word per request: done is high for one cycle with
//   status, address, bytes_in_use and live_allocations valid in that cycle
//   the receiver cannot stall; done is not held and never repeats
// operation, one request at a time
//   allocate: search the allocation slots for a free one, scan the free
//   ranges (read, load, align, compare each; low stops at the first fit),
//   place, then shift range entries on a split or when the range empties
//   free: search the allocation slots for the address, pass the free
//   ranges below it, then a merge or an insert/remove shift of entries
// configuration
//   cfg_we with cfg_index writes base address (0) or heap capacity (1); a
//   nonzero capacity empties the heap into one free range; write only idle
// reset
//   tables hold one free range over the full heap; busy stays high for one
//   cycle after reset while the first free range entry is written
// ---------------------------------------------------------------------------
module range_heap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [rha_pkg::OFF_W-1:0]     request_size,
	input  logic [rha_pkg::OFF_W-1:0]     alignment,
	input  logic [rha_pkg::ADDR_W-1:0]    free_address,
	// result
	output logic                          done,
	output logic [2:0]                    status,
	output logic [rha_pkg::ADDR_W-1:0]    address,
	output logic [rha_pkg::OFF_W-1:0]     bytes_in_use,
	output logic [rha_pkg::LIVE_W-1:0]    live_allocations,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [rha_pkg::CFG_W-1:0]     cfg_wdata
);

	rha_pkg::rha_cmd_t cmd;
	rha_pkg::rha_sts_t sts;

	// sequencer: one state per step of a request
	rha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// tables, scan registers and result registers
	rha_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.mode             (mode),
		.request_size     (request_size),
		.alignment        (alignment),
		.free_address     (free_address),
		.done             (done),
		.status           (status),
		.address          (address),
		.bytes_in_use     (bytes_in_use),
		.live_allocations (live_allocations)
	);

	// one result per request, and the block is idle when it shows
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe repeated");
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request taken but block not busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		live_allocations <= rha_pkg::LIVE_W'(rha_pkg::MAX_ALLOCATIONS))
		else $error("live allocation count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != rha_pkg::ST_OK) |-> (address == '0))
		else $error("failed request reports an address");

endmodule

// ===== verif/tb_range_heap_allocator.sv =====
// ---------------------------------------------------------------------------
// tb_range_heap_allocator: self-checking bench for the range heap allocator
// a queue-fed driver issues request words, a clocked monitor checks each
// result word against a behavioral heap model updated at acceptance
// ---------------------------------------------------------------------------
module tb_range_heap_allocator;

	localparam int LIMIT_CYCLES = 4000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [1:0]                mode;
		logic [rha_pkg::OFF_W-1:0] size;
		logic [rha_pkg::OFF_W-1:0] align;
		logic [31:0]               faddr;
		int                        gap;
	} req_word_t;

	typedef struct {
		logic [2:0]                 status;
		logic [31:0]                address;
		logic [rha_pkg::OFF_W-1:0]  bytes;
		logic [rha_pkg::LIVE_W-1:0] live;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] mode = 2'd0;
	logic [rha_pkg::OFF_W-1:0] request_size = '0;
	logic [rha_pkg::OFF_W-1:0] alignment = '0;
	logic [31:0] free_address = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [rha_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic busy, done;
	logic [2:0] status;
	logic [31:0] address;
	logic [rha_pkg::OFF_W-1:0] bytes_in_use;
	logic [rha_pkg::LIVE_W-1:0] live_allocations;

	range_heap_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.request_size(request_size), .alignment(alignment), .free_address(free_address),
		.done(done), .status(status), .address(address), .bytes_in_use(bytes_in_use),
		.live_allocations(live_allocations), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---- heap model state
	int unsigned m_base;
	int unsigned m_cap;
	int unsigned fr_off [rha_pkg::MAX_FREE_RANGES];
	int unsigned fr_len [rha_pkg::MAX_FREE_RANGES];
	int unsigned fr_cnt;
	int unsigned al_off [rha_pkg::MAX_ALLOCATIONS];
	int unsigned al_len [rha_pkg::MAX_ALLOCATIONS];
	bit          al_vld [rha_pkg::MAX_ALLOCATIONS];
	int unsigned m_used;
	int unsigned m_live;

	req_word_t pending_words[$];
	rsp_word_t expected_words[$];
	int errors = 0;
	int cycles = 0;

	task automatic heap_clear();
		fr_cnt = 0;
		if (m_cap != 0) begin
			fr_off[0] = 0;
			fr_len[0] = m_cap;
			fr_cnt = 1;
		end
		foreach (al_vld[i]) al_vld[i] = 1'b0;
		m_used = 0;
		m_live = 0;
	endtask

	task automatic heap_write_reg(input logic idx, input int unsigned val);
		int unsigned v;
		if (idx == rha_pkg::REG_BASE) begin
			m_base = val;
		end else begin
			v = val & 32'h1F_FFFF;
			m_cap = (v > (1 << rha_pkg::HEAP_BITS)) ? (1 << rha_pkg::HEAP_BITS) : v;
			heap_clear();
		end
	endtask

	task automatic range_remove(input int unsigned i);
		for (int unsigned k = i; k + 1 < fr_cnt; k++) begin
			fr_off[k] = fr_off[k+1];
			fr_len[k] = fr_len[k+1];
		end
		fr_cnt--;
	endtask

	task automatic range_insert(input int unsigned i, input int unsigned off,
			input int unsigned len);
		for (int k = int'(fr_cnt) - 1; k >= int'(i); k--) begin
			fr_off[k+1] = fr_off[k];
			fr_len[k+1] = fr_len[k];
		end
		fr_off[i] = off;
		fr_len[i] = len;
		fr_cnt++;
	endtask

	task automatic heap_alloc(input bit high, input int unsigned size,
			input int unsigned align, output rha_pkg::result_code_t st,
			output logic [31:0] a_out);
		int slot, pick;
		longint unsigned best, amask, s, room, a;
		int unsigned at, tail;
		slot = -1;
		pick = -1;
		best = 0;
		a_out = '0;
		if (size == 0 || align == 0 || (align & (align - 1)) != 0) begin
			st = rha_pkg::ST_BAD;
			return;
		end
		for (int i = 0; i < rha_pkg::MAX_ALLOCATIONS; i++)
			if (!al_vld[i]) begin slot = i; break; end
		if (slot < 0) begin
			st = rha_pkg::ST_FULL;
			return;
		end
		amask = ~(64'(align) - 64'd1);
		for (int i = 0; i < int'(fr_cnt); i++) begin
			s = 64'(m_base) + 64'(fr_off[i]);
			if (fr_len[i] < size) continue;
			room = 64'(fr_len[i] - size);
			a = high ? ((s + room) & amask) : ((s + 64'(align) - 64'd1) & amask);
			if (a < s || a - s > room) continue;
			if (pick < 0 || (high && a > best)) begin
				pick = i;
				best = a;
				if (!high) break;
			end
		end
		if (pick < 0) begin
			st = rha_pkg::ST_NOFIT;
			return;
		end
		at = 32'(best - 64'(m_base));
		if (at == fr_off[pick]) begin
			// placement at the range start shrinks it, and removes it once empty
			fr_off[pick] += size;
			fr_len[pick] -= size;
			if (fr_len[pick] == 0) range_remove(pick);
		end else begin
			tail = fr_off[pick] + fr_len[pick] - (at + size);
			if (tail != 0 && fr_cnt >= rha_pkg::MAX_FREE_RANGES) begin
				st = rha_pkg::ST_FULL;
				return;
			end
			fr_len[pick] = at - fr_off[pick];
			if (tail != 0) range_insert(pick + 1, at + size, tail);
		end
		al_off[slot] = at;
		al_len[slot] = size;
		al_vld[slot] = 1'b1;
		m_used = (m_used + size) & 32'h1F_FFFF;
		m_live++;
		a_out = best[31:0];
		st = rha_pkg::ST_OK;
	endtask

	task automatic heap_release(input logic [31:0] faddr,
			output rha_pkg::result_code_t st);
		int slot;
		int unsigned pos, off, len;
		bit jn, jp;
		slot = -1;
		for (int i = 0; i < rha_pkg::MAX_ALLOCATIONS; i++)
			if (al_vld[i] && (m_base + al_off[i]) == faddr) begin slot = i; break; end
		if (slot < 0) begin
			st = rha_pkg::ST_NOTFOUND;
			return;
		end
		off = al_off[slot];
		len = al_len[slot];
		pos = 0;
		while (pos < fr_cnt && fr_off[pos] < off) pos++;
		jn = pos < fr_cnt && off + len == fr_off[pos];
		jp = pos > 0 && fr_off[pos-1] + fr_len[pos-1] == off;
		if (!jn && !jp && fr_cnt >= rha_pkg::MAX_FREE_RANGES) begin
			st = rha_pkg::ST_FULL;
			return;
		end
		if (jp && jn) begin
			fr_len[pos-1] += len + fr_len[pos];
			range_remove(pos);
		end else if (jp) begin
			fr_len[pos-1] += len;
		end else if (jn) begin
			fr_off[pos] = off;
			fr_len[pos] += len;
		end else begin
			range_insert(pos, off, len);
		end
		al_vld[slot] = 1'b0;
		m_used = (m_used - len) & 32'h1F_FFFF;
		m_live--;
		st = rha_pkg::ST_OK;
	endtask

	task automatic heap_predict(input req_word_t w, output rsp_word_t r);
		rha_pkg::result_code_t st;
		logic [31:0] a;
		a = '0;
		if (w.mode == rha_pkg::MODE_LOW || w.mode == rha_pkg::MODE_HIGH)
			heap_alloc(w.mode == rha_pkg::MODE_HIGH, 32'(w.size), 32'(w.align), st, a);
		else if (w.mode == rha_pkg::MODE_FREE)
			heap_release(w.faddr, st);
		else
			st = rha_pkg::ST_BAD;
		r.status = st;
		r.address = (st == rha_pkg::ST_OK) ? a : 32'd0;
		r.bytes = m_used[rha_pkg::OFF_W-1:0];
		r.live = m_live[rha_pkg::LIVE_W-1:0];
	endtask

	// ---- driver: one word in flight on the ports, gap counted before start
	req_word_t cur_word;
	bit have_word = 1'b0;
	int gap_left = 0;

	always @(posedge clk) begin
		rsp_word_t r;
		if (arst_n) begin
			if (start && !busy) begin
				// word taken at this edge, model advances in order
				heap_predict(cur_word, r);
				expected_words.push_back(r);
				have_word = 1'b0;
			end
			if (!have_word && pending_words.size() > 0) begin
				cur_word = pending_words.pop_front();
				gap_left = cur_word.gap;
				have_word = 1'b1;
			end
			if (have_word && gap_left == 0) begin
				start <= 1'b1;
				mode <= cur_word.mode;
				request_size <= cur_word.size;
				alignment <= cur_word.align;
				free_address <= cur_word.faddr;
			end else begin
				if (have_word) gap_left--;
				start <= 1'b0;
			end
		end
	end

	task automatic report(input string what, input longint unsigned want,
			input longint unsigned got);
		$display("mismatch %s: expected %0h got %0h", what, want, got);
		errors++;
	endtask

	// ---- monitor: done is a one-cycle strobe, checked at the closing edge
	always @(posedge clk) begin
		rsp_word_t e;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report("unexpected result word", 64'd0, 64'(status));
			end else begin
				e = expected_words.pop_front();
				if (status !== e.status) report("status", 64'(e.status), 64'(status));
				if (address !== e.address) report("address", 64'(e.address), 64'(address));
				if (bytes_in_use !== e.bytes)
					report("bytes_in_use", 64'(e.bytes), 64'(bytes_in_use));
				if (live_allocations !== e.live)
					report("live_allocations", 64'(e.live), 64'(live_allocations));
			end
		end
	end

	// ---- watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_range_heap_allocator NOT OK");
			$finish;
		end
	end

	// ---- stimulus helpers
	task automatic push_word(input logic [1:0] md, input int unsigned sz,
			input int unsigned al, input logic [31:0] fa, input int gap);
		req_word_t w;
		w.mode = md;
		w.size = sz[rha_pkg::OFF_W-1:0];
		w.align = al[rha_pkg::OFF_W-1:0];
		w.faddr = fa;
		w.gap = gap;
		pending_words.push_back(w);
	endtask

	task automatic wait_idle();
		wait (pending_words.size() == 0 && !have_word && expected_words.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		heap_write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// address of some live allocation, or noise when none is live
	function automatic logic [31:0] live_address();
		int s;
		s = $urandom_range(0, rha_pkg::MAX_ALLOCATIONS - 1);
		for (int k = 0; k < rha_pkg::MAX_ALLOCATIONS; k++) begin
			if (al_vld[(s + k) % rha_pkg::MAX_ALLOCATIONS])
				return m_base + al_off[(s + k) % rha_pkg::MAX_ALLOCATIONS];
		end
		return $urandom();
	endfunction

	int unsigned caps [10] = '{4096, 256, 1, 0, 2097151, 1048576, 65536, 1024, 777, 300};
	int unsigned bases [10] = '{0, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_F000, 0,
		32'h1234_5677, 32'h8000_0001, 0, 32'hFFFF_FFF0, 32'h0000_0100};

	initial begin
		int unsigned cap, sz, al, pick;
		int free_pct, gap;
		bit burst;
		heap_write_reg(rha_pkg::REG_BASE, 0);
		heap_write_reg(rha_pkg::REG_CAP, 1048576);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at reset settings
		push_word(rha_pkg::MODE_LOW, 1, 1, 0, 0);
		push_word(rha_pkg::MODE_HIGH, 16, 16, 0, 0);
		push_word(rha_pkg::MODE_LOW, 0, 1, 0, 1);                 // size zero
		push_word(rha_pkg::MODE_LOW, 8, 0, 0, 0);                 // alignment zero
		push_word(rha_pkg::MODE_HIGH, 8, 3, 0, 2);                // alignment not a power of two
		push_word(2'd3, 5, 4, 0, 0);                              // unused mode
		push_word(rha_pkg::MODE_FREE, 0, 0, 32'd0, 0);            // free at address zero
		push_word(rha_pkg::MODE_FREE, 0, 0, 32'hDEAD_BEEF, 3);    // not found
		push_word(rha_pkg::MODE_LOW, 1048576, 1048576, 0, 0);     // no fit, heap partly used
		push_word(rha_pkg::MODE_LOW, 2097151, 2097151, 0, 0);     // all ones fields
		push_word(rha_pkg::MODE_LOW, 100, 1048576, 0, 0);
		push_word(rha_pkg::MODE_HIGH, 100, 1024, 0, 0);
		push_word(rha_pkg::MODE_LOW, 64, 64, 0, 7);
		push_word(rha_pkg::MODE_FREE, 0, 0, 32'h000F_FFF0, 0);    // free the high block
		push_word(rha_pkg::MODE_FREE, 0, 0, 32'hFFFF_FFFF, 0);
		push_word(rha_pkg::MODE_LOW, 1048576 - 300, 1, 0, 0);
		push_word(rha_pkg::MODE_HIGH, 1048576, 1, 0, 0);
		wait_idle();
		write_reg(rha_pkg::REG_CAP, 1048576);
		push_word(rha_pkg::MODE_LOW, 1048576, 1048576, 0, 0);     // whole heap in one
		push_word(rha_pkg::MODE_FREE, 0, 0, 32'd0, 0);
		wait_idle();

		// random phases, several settings each
		for (int ph = 0; ph < 11; ph++) begin
			write_reg(rha_pkg::REG_BASE, (ph == 10) ? $urandom() : bases[ph % 10]);
			if (ph % 4 != 3)
				write_reg(rha_pkg::REG_CAP, (ph == 10) ? $urandom() : caps[ph % 10]);
			cap = m_cap;
			free_pct = $urandom_range(10, 45);
			burst = (ph % 3 == 1);
			for (int n = 0; n < 150; n++) begin
				wait (pending_words.size() < 2);
				@(negedge clk);
				gap = burst ? 0 : $urandom_range(0, 7);
				sz = $urandom_range(1, (cap > 64) ? cap / 16 : 4);
				al = 1 << $urandom_range(0, 12);
				pick = $urandom_range(0, 99);
				if (pick < free_pct) begin
					push_word(rha_pkg::MODE_FREE, $urandom(), $urandom(), live_address(), gap);
				end else if (pick < 92) begin
					if ($urandom_range(0, 19) == 0) al = 1 << $urandom_range(13, 20);
					if ($urandom_range(0, 19) == 0) sz = $urandom_range(1, cap + 2);
					push_word(($urandom_range(0, 2) == 0) ? rha_pkg::MODE_HIGH
						: rha_pkg::MODE_LOW, sz, al, $urandom(), gap);
				end else begin
					// noise: raw fields, odd modes and stray addresses
					push_word(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
						gap);
				end
			end
			wait_idle();
		end

		if (errors == 0) begin
			$display("tb_range_heap_allocator OK");
		end else begin
			$display("tb_range_heap_allocator NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rha_pkg.sv
rtl/rha_ctrl.sv
rtl/rha_dp.sv
rtl/range_heap_allocator.sv
verif/tb_range_heap_allocator.sv
